// File: sv/binary_min_heap_queue_core_macros.svh
// Assertion helpers shared by the heap queue RTL.
// Both sample on clk and are switched off while rst_n is low.
`ifndef BINARY_MIN_HEAP_QUEUE_CORE_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BMHQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BMHQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/bmhq_pkg.sv
`default_nettype none
package bmhq_pkg;

  // Heap geometry
  localparam int DEPTH   = 256;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int COUNT_W = ADDR_W + 1;
  localparam int IDX_W   = ADDR_W + 2;
  localparam int KEY_W   = 16;
  localparam int PAY_W   = 32;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [PAY_W-1:0]        pay_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [COUNT_W-1:0]      count_t;
  typedef logic [IDX_W-1:0]        idx_t;

  typedef struct packed {
    key_t key;
    pay_t pay;
  } entry_t;

  // Item action codes
  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Request to the shared comparator
  typedef struct packed {
    key_t probe;
    key_t key_a;
    key_t key_b;
    logic use_b;
  } cmp_req_t;

  // Comparator answer: chosen child and probe against it
  typedef struct packed {
    logic sel_b;
    logic lt;
    logic le;
  } cmp_res_t;

  // Parent slot of a heap slot above the root
  function automatic addr_t parent_of(input addr_t idx);
    addr_t dec;
    dec = idx - addr_t'(1);
    return dec >> 1;
  endfunction

endpackage
`default_nettype wire

// File: sv/binary_min_heap_queue_core.sv
`default_nettype none
`include "binary_min_heap_queue_core_macros.svh"
// Min-heap priority queue of 256 entries (16-bit signed key, 32-bit payload).
// Raise start with the item fields while busy is low; the item is taken on that
// edge. Exactly one result follows as a single-cycle out_valid pulse, and it
// cannot be held off: capture it on that cycle. A full insert or an empty
// remove answers on the next cycle. Otherwise the sift walks one tree level
// per cycle through the single comparator, fed by the registered entry
// store with its two read ports, plus a read before and a write after.
module binary_min_heap_queue_core
  import bmhq_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  wire                 in_action,
  input  wire signed [KEY_W-1:0] in_priority_req,
  input  wire [PAY_W-1:0]     in_payload,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [PAY_W-1:0]    out_payload,
  output logic [COUNT_W-1:0]  out_entry_count
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_INS_RD  = 8'b0000_0010,
    S_INS_CMP = 8'b0000_0100,
    S_INS_FIN = 8'b0000_1000,
    S_RM_RD   = 8'b0001_0000,
    S_RM_LAST = 8'b0010_0000,
    S_RM_CMP  = 8'b0100_0000,
    S_RM_FIN  = 8'b1000_0000
  } state_t;

  state_t  state_r, state_nxt;
  count_t  count_r, count_nxt;
  logic    out_valid_r, out_valid_nxt;
  status_t out_status_r, out_status_nxt;
  count_t  out_count_r, out_count_nxt;
  pay_t    out_pay_r, out_pay_nxt;

  // Working registers of the current item
  entry_t  new_r, new_nxt;
  entry_t  last_r, last_nxt;
  addr_t   slot_r, slot_nxt;
  idx_t    child_r, child_nxt;

  logic    wr_en;
  addr_t   wr_addr;
  entry_t  wr_data;
  addr_t   rd_a_addr, rd_b_addr;
  entry_t  rd_a_data, rd_b_data;

  cmp_req_t cmp_req;
  cmp_res_t cmp_res;

  logic    accept;
  addr_t   up_slot;
  idx_t    sel_idx;
  idx_t    sel_child;
  idx_t    count_ext;

  bmhq_store u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

  bmhq_cmp u_cmp (
    .req (cmp_req),
    .res (cmp_res)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Helpers for the walk through the tree
  always_comb begin
    up_slot   = parent_of(slot_r);
    count_ext = idx_t'(count_r);
    sel_idx   = child_r + idx_t'(cmp_res.sel_b);
    sel_child = {sel_idx[IDX_W-2:0], 1'b1};
  end

  // Feed the shared comparator
  always_comb begin
    cmp_req.key_a = rd_a_data.key;
    cmp_req.key_b = rd_b_data.key;
    cmp_req.use_b = (state_r == S_RM_CMP) && ((child_r + idx_t'(1)) < count_ext);
    cmp_req.probe = (state_r == S_RM_CMP) ? last_r.key : new_r.key;
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_pay_nxt    = out_pay_r;
    new_nxt        = new_r;
    last_nxt       = last_r;
    slot_nxt       = slot_r;
    child_nxt      = child_r;
    wr_en          = 1'b0;
    wr_addr        = slot_r;
    wr_data        = new_r;
    rd_a_addr      = parent_of(slot_r);
    rd_b_addr      = addr_t'(count_r - count_t'(1));

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          new_nxt.key = in_priority_req;
          new_nxt.pay = in_payload;
          slot_nxt    = count_r[ADDR_W-1:0];
          if (in_action == ACT_INSERT) begin
            if (count_r >= count_t'(DEPTH)) begin
              // Drop the item, report full
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_FULL;
              out_pay_nxt    = '0;
              out_count_nxt  = count_r;
            end else if (count_r == '0) begin
              state_nxt = S_INS_FIN;
            end else begin
              state_nxt = S_INS_RD;
            end
          end else begin
            if (count_r == '0) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_EMPTY;
              out_pay_nxt    = '0;
              out_count_nxt  = count_r;
            end else begin
              state_nxt = S_RM_RD;
            end
          end
        end
      end

      S_INS_RD: begin
        // Fetch the parent of the free slot
        rd_a_addr = up_slot;
        state_nxt = S_INS_CMP;
      end

      S_INS_CMP: begin
        wr_en     = 1'b1;
        rd_a_addr = parent_of(up_slot);
        if (cmp_res.lt) begin
          // Move the parent down, climb one level
          wr_data  = rd_a_data;
          slot_nxt = up_slot;
          if (up_slot == '0) begin
            state_nxt = S_INS_FIN;
          end
        end else begin
          state_nxt      = S_IDLE;
          count_nxt      = count_r + count_t'(1);
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_DONE;
          out_pay_nxt    = '0;
          out_count_nxt  = count_r + count_t'(1);
        end
      end

      S_INS_FIN: begin
        wr_en          = 1'b1;
        state_nxt      = S_IDLE;
        count_nxt      = count_r + count_t'(1);
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_DONE;
        out_pay_nxt    = '0;
        out_count_nxt  = count_r + count_t'(1);
      end

      S_RM_RD: begin
        // Fetch the root and the last entry together
        rd_a_addr = '0;
        rd_b_addr = addr_t'(count_r - count_t'(1));
        state_nxt = S_RM_LAST;
      end

      S_RM_LAST: begin
        out_pay_nxt = rd_a_data.pay;
        last_nxt    = rd_b_data;
        count_nxt   = count_r - count_t'(1);
        slot_nxt    = '0;
        child_nxt   = idx_t'(1);
        rd_a_addr   = addr_t'(1);
        rd_b_addr   = addr_t'(2);
        if (count_r > count_t'(2)) begin
          state_nxt = S_RM_CMP;
        end else begin
          state_nxt = S_RM_FIN;
        end
      end

      S_RM_CMP: begin
        wr_en     = 1'b1;
        rd_a_addr = sel_child[ADDR_W-1:0];
        rd_b_addr = addr_t'(sel_child + idx_t'(1));
        if (cmp_res.le) begin
          // Settle the moved entry here
          wr_data        = last_r;
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_DONE;
          out_count_nxt  = count_r;
        end else begin
          // Lift the smaller child, descend one level
          wr_data   = cmp_res.sel_b ? rd_b_data : rd_a_data;
          slot_nxt  = sel_idx[ADDR_W-1:0];
          child_nxt = sel_child;
          if (sel_child >= count_ext) begin
            state_nxt = S_RM_FIN;
          end
        end
      end

      S_RM_FIN: begin
        wr_en          = 1'b1;
        wr_data        = last_r;
        state_nxt      = S_IDLE;
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_DONE;
        out_count_nxt  = count_r;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_pay_r    <= out_pay_nxt;
    new_r        <= new_nxt;
    last_r       <= last_nxt;
    slot_r       <= slot_nxt;
    child_r      <= child_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_payload     = out_pay_r;
  assign out_entry_count = out_count_r;

  `BMHQ_ASSERT_SAME(a_count_bound, 1'b1, count_r <= count_t'(DEPTH),
    "entry count beyond depth")
  `BMHQ_ASSERT_SAME(a_strobe_idle, out_valid_r, state_r == S_IDLE,
    "result strobe while an item is still at work")
  `BMHQ_ASSERT_NEXT(a_accept_moves, accept, busy || out_valid,
    "accepted item neither started nor answered")
  `BMHQ_ASSERT_SAME(a_full_count, out_valid_r && (out_status_r == ST_FULL),
    out_count_r == count_t'(DEPTH), "full status with room left")
  `BMHQ_ASSERT_SAME(a_empty_zero, out_valid_r && (out_status_r == ST_EMPTY),
    (out_pay_r == '0) && (out_count_r == '0), "empty status with data")

endmodule
`default_nettype wire

// File: sv/bmhq_store.sv
`default_nettype none
module bmhq_store
  import bmhq_pkg::*;
(
  input  wire    clk,
  input  wire    wr_en,
  input  addr_t  wr_addr,
  input  entry_t wr_data,
  input  addr_t  rd_a_addr,
  input  addr_t  rd_b_addr,
  output entry_t rd_a_data,
  output entry_t rd_b_data
);

  entry_t mem [DEPTH];

  // Write one slot per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read two slots per cycle, registered
  always_ff @(posedge clk) begin
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule
`default_nettype wire

// File: sv/bmhq_cmp.sv
`default_nettype none
module bmhq_cmp
  import bmhq_pkg::*;
(
  input  cmp_req_t req,
  output cmp_res_t res
);

  logic sel_b;
  key_t chosen;

  // Pick the left child unless the right one is strictly smaller
  always_comb begin
    sel_b  = req.use_b && ($signed(req.key_a) > $signed(req.key_b));
    chosen = sel_b ? req.key_b : req.key_a;
  end

  // Rank the probe key against the chosen one
  assign res.sel_b = sel_b;
  assign res.lt    = $signed(req.probe) <  $signed(chosen);
  assign res.le    = $signed(req.probe) <= $signed(chosen);

endmodule
`default_nettype wire

// File: sim/binary_min_heap_queue_core_test.sv
`timescale 1ns / 100ps

import bmhq_pkg::*;

typedef struct packed {
  status_t status;
  pay_t    pay;
  count_t  cnt;
} heap_result_t;

// Track heap contents and the results still owed by the block
class heap_queue_scoreboard;
  key_t         key_store [DEPTH];
  pay_t         pay_store [DEPTH];
  int           fill;
  heap_result_t pending_results [$];
  int           mismatch_count;

  function new();
    fill = 0;
    mismatch_count = 0;
  endfunction

  // Sift a new entry up; an equal key stays below its parent
  function status_t push_entry(key_t key, pay_t pay);
    int slot;
    int up;
    if (fill >= DEPTH) return ST_FULL;
    slot = fill;
    while (slot > 0 && key < key_store[(slot - 1) / 2]) begin
      up = (slot - 1) / 2;
      key_store[slot] = key_store[up];
      pay_store[slot] = pay_store[up];
      slot = up;
    end
    key_store[slot] = key;
    pay_store[slot] = pay;
    fill++;
    return ST_DONE;
  endfunction

  // Take the root, move the last entry to the top and sift it down
  function status_t pop_min(output pay_t top);
    int   parent;
    int   child;
    key_t last_key;
    pay_t last_pay;
    if (fill == 0) begin
      top = '0;
      return ST_EMPTY;
    end
    top = pay_store[0];
    last_key = key_store[fill - 1];
    last_pay = pay_store[fill - 1];
    fill--;
    parent = 0;
    child = 1;
    while (child < fill) begin
      if (child + 1 < fill && key_store[child] > key_store[child + 1]) child++;
      if (last_key <= key_store[child]) break;
      key_store[parent] = key_store[child];
      pay_store[parent] = pay_store[child];
      parent = child;
      child = 2 * parent + 1;
    end
    key_store[parent] = last_key;
    pay_store[parent] = last_pay;
    return ST_DONE;
  endfunction

  // Predict the result of an accepted item and queue it
  function void note_item(action_t act, key_t key, pay_t pay);
    heap_result_t want;
    pay_t         top;
    top = '0;
    if (act == ACT_INSERT) want.status = push_entry(key, pay);
    else want.status = pop_min(top);
    want.pay = top;
    want.cnt = count_t'(fill);
    pending_results.push_back(want);
  endfunction

  // Compare a result strobe with the oldest prediction
  function void check_result(logic [1:0] st, pay_t pay, count_t cnt);
    heap_result_t want;
    if (pending_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: unexpected result status=%0d payload=%h count=%0d",
                 $time, st, pay, cnt);
      return;
    end
    want = pending_results.pop_front();
    if (st !== want.status || pay !== want.pay || cnt !== want.cnt) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: mismatch status %0d/%0d payload %h/%h count %0d/%0d (exp/got)",
                 $time, want.status, st, want.pay, pay, want.cnt, cnt);
    end
  endfunction
endclass

module binary_min_heap_queue_core_test;
  localparam int CYCLE_LIMIT = 400000;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic       in_action;
  key_t       in_priority_req;
  pay_t       in_payload;
  logic       out_valid;
  logic [1:0] out_status;
  pay_t       out_payload;
  count_t     out_entry_count;

  heap_queue_scoreboard sb;
  int cycle_count;
  bit calm;
  int extra;

  binary_min_heap_queue_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_priority_req (in_priority_req),
    .in_payload      (in_payload),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_payload     (out_payload),
    .out_entry_count (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Check results before noting a new item on the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_status, out_payload, out_entry_count);
      if (start && !busy) sb.note_item(action_t'(in_action), in_priority_req, in_payload);
    end
  end

  // Mostly short gaps, a few long ones, none during calm stretches
  function automatic int next_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Extremes, clustered keys for ties, and full-range keys
  function automatic key_t pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 15) begin
      case ($urandom_range(3))
        0: return key_t'(16'sh8000);
        1: return key_t'(16'sh7fff);
        2: return key_t'(0);
        default: return key_t'(-1);
      endcase
    end
    if (r < 45) return key_t'(int'($urandom_range(8)) - 4);
    return key_t'($urandom);
  endfunction

  // Present an item at the falling edge and hold it until taken
  task automatic send_item(action_t act, key_t key, pay_t pay, int gap);
    in_action = act;
    in_priority_req = key;
    in_payload = pay;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_random(int insert_pct);
    action_t act;
    act = ($urandom_range(99) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
    send_item(act, pick_key(), pay_t'($urandom), next_gap());
  endtask

  // Hold off the sender until every result has come back
  task automatic drain_results();
    start = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_action = ACT_INSERT;
    in_priority_req = '0;
    in_payload = '0;
    calm = 1'b0;
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: remove on empty, key extremes, equal keys, drain past empty
    send_item(ACT_REMOVE, key_t'(0), pay_t'(0), next_gap());
    send_item(ACT_INSERT, key_t'(100), 32'hffff_ffff, next_gap());
    send_item(ACT_INSERT, key_t'(16'sh8000), 32'h0000_0000, next_gap());
    send_item(ACT_INSERT, key_t'(16'sh7fff), 32'h7fff_0001, next_gap());
    send_item(ACT_INSERT, key_t'(0), 32'h0000_0003, next_gap());
    send_item(ACT_INSERT, key_t'(-1), 32'h8000_0000, next_gap());
    send_item(ACT_INSERT, key_t'(5), 32'h0000_00a1, next_gap());
    send_item(ACT_INSERT, key_t'(5), 32'h0000_00a2, next_gap());
    send_item(ACT_INSERT, key_t'(5), 32'h0000_00a3, next_gap());
    send_item(ACT_INSERT, key_t'(16'sh8000), 32'h5555_aaaa, next_gap());
    repeat (10) send_item(ACT_REMOVE, pick_key(), pay_t'($urandom), next_gap());

    // Mixed traffic around a shallow heap
    for (int i = 0; i < 150; i++) begin
      if (i % 40 == 0) calm = ($urandom_range(3) == 0);
      if (i == 75) drain_results();
      send_random(55);
    end

    // Fill to capacity, then push a few more at full
    extra = 0;
    while (sb.fill < DEPTH || extra < 6) begin
      if ($urandom_range(39) == 0) calm = ~calm;
      if (sb.fill >= DEPTH) extra++;
      send_random(92);
    end

    // Drain to empty, then remove a few more on empty
    extra = 0;
    while (sb.fill > 0 || extra < 6) begin
      if ($urandom_range(39) == 0) calm = ~calm;
      if (sb.fill == 0) extra++;
      send_random(8);
    end

    // Wait for the last results, then a little longer
    drain_results();
    repeat (20) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// File: binary_min_heap_queue_core.f
+incdir+sv
sv/bmhq_pkg.sv
sv/bmhq_store.sv
sv/bmhq_cmp.sv
sv/binary_min_heap_queue_core.sv
sim/binary_min_heap_queue_core_test.sv
